/* rtl/core/hcl_pkg.sv */
package hcl_pkg;

    // Fraction bits of the luminance tables (unsigned Q0.n).
    localparam int LUMA_FRACTION_BITS = 16;
    // Each weighted entry stays below 1.0, so n bits hold it.
    localparam int LUMA_ROM_W = LUMA_FRACTION_BITS;
    // Sum of three entries.
    localparam int LUMA_SUM_W = LUMA_FRACTION_BITS + 2;
    localparam logic [LUMA_SUM_W-1:0] LUMA_HALF =
        LUMA_SUM_W'(1) << (LUMA_FRACTION_BITS - 1);

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYSTEM_PREFERS_DARK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DARK_BACKGROUND     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_BACKGROUND    = 2'd2;

    localparam logic [31:0] DARK_BACKGROUND_RESET  = 32'hFF00_0000;
    localparam logic [31:0] LIGHT_BACKGROUND_RESET = 32'hFFFF_FFFF;
    localparam logic [7:0]  OPAQUE_ALPHA           = 8'hFF;

    // Scan phase of the string parser.
    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_BODY  = 2'd1,
        PH_TRAIL = 2'd2
    } scan_phase_t;

    // Parse outcome handed from the parser to the result stage.
    typedef struct packed {
        logic        ok;
        logic [31:0] color;
    } parse_res_t;

    // One luminance table: 256 entries, packed so it can be built by a function.
    typedef logic [255:0][LUMA_ROM_W-1:0] luma_table_t;

    // Constants of the table generator.
    localparam logic [63:0] ONE_Q60    = 64'd1 << 60;
    localparam logic [63:0] LIN_DIV    = 64'd65892000;
    localparam logic [63:0] LIN_HALF   = 64'd32946000;
    localparam logic [63:0] POW_DEN    = 64'd269025;
    localparam logic [63:0] POW_DIV    = 64'd2560000;
    localparam logic [63:0] POW_HALF   = 64'd1280000;
    localparam int          POW_SHIFT  = 52 - LUMA_FRACTION_BITS;
    localparam logic [63:0] WEIGHT_R   = 64'd2126;
    localparam logic [63:0] WEIGHT_G   = 64'd7152;
    localparam logic [63:0] WEIGHT_B   = 64'd722;

    // Product of two Q60 values no larger than 1.0, truncated.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [63:0] pow5_q60(input logic [63:0] t);
        logic [63:0] t2;
        t2 = mul_q60(t, t);
        return mul_q60(mul_q60(t2, t2), t);
    endfunction

    // Largest Q60 value whose fifth power does not exceed x (binary search).
    function automatic logic [63:0] root5_q60(input logic [63:0] x);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 64'd0;
        hi = ONE_Q60;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (pow5_q60(mid) <= x) begin
                lo = mid;
            end
            else begin
                hi = mid - 64'd1;
            end
        end
        return lo;
    endfunction

    // Weighted, linearized channel value in Q0.n, rounded to nearest.
    function automatic logic [LUMA_ROM_W-1:0] luma_entry(input logic [63:0] w,
                                                          input int v);
        logic [63:0]  vv;
        logic [63:0]  num;
        logic [63:0]  n;
        logic [63:0]  r;
        logic [63:0]  rem;
        logic [63:0]  x2;
        logic [63:0]  lin;
        logic [127:0] p;
        logic [63:0]  m;
        vv = 64'(v);
        if (vv * 64'd100000 <= 64'd1001640) begin
            // Linear segment: w * v / (255 * 12.92), exact integer form.
            num = (64'd2 * w * vv) << LUMA_FRACTION_BITS;
            return LUMA_ROM_W'((num + LIN_HALF) / LIN_DIV);
        end
        else begin
            // Power segment: ((v/255 + 0.055) / 1.055) in Q60 by long division.
            n   = 64'd1000 * vv + 64'd14025;
            r   = n / POW_DEN;
            rem = n % POW_DEN;
            for (int i = 0; i < 60; i++) begin
                rem = rem << 1;
                r   = r << 1;
                if (rem >= POW_DEN) begin
                    rem = rem - POW_DEN;
                    r   = r | 64'd1;
                end
            end
            // x^2.4 = x^2 * fifth root of x^2.
            x2  = mul_q60(r, r);
            lin = mul_q60(x2, root5_q60(x2));
            p   = {64'd0, lin} * {64'd0, w};
            m   = p[POW_SHIFT +: 64];
            return LUMA_ROM_W'((m + POW_HALF) / POW_DIV);
        end
    endfunction

    function automatic luma_table_t build_luma_table(input logic [63:0] w);
        luma_table_t t;
        for (int v = 0; v < 256; v++) begin
            t[v] = luma_entry(w, v);
        end
        return t;
    endfunction

    localparam luma_table_t LUMA_ROM_R = build_luma_table(WEIGHT_R);
    localparam luma_table_t LUMA_ROM_G = build_luma_table(WEIGHT_G);
    localparam luma_table_t LUMA_ROM_B = build_luma_table(WEIGHT_B);

endpackage

/* rtl/core/hcl_ifs.sv */
// Character stream channel.
interface hcl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// Parse result channel.
interface hcl_result_if;
    logic        valid;
    logic        ready;
    logic        parsed_ok;
    logic [31:0] color_argb;
    logic [31:0] background_argb;
    logic        theme_is_dark;

    modport source (output valid, output parsed_ok, output color_argb,
                    output background_argb, output theme_is_dark, input ready);
    modport sink   (input valid, input parsed_ok, input color_argb,
                    input background_argb, input theme_is_dark, output ready);
endinterface

// Configuration write channel.
interface hcl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/hcl_parser.sv */
module hcl_parser
    import hcl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] text_char,
    input  logic       last_char,
    output parse_res_t res
);

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [3:0]  count_reg;
    logic [3:0]  count_next;
    scan_phase_t phase_reg;
    scan_phase_t phase_next;
    logic        bad_reg;
    logic        bad_next;
    parse_res_t  res_reg;
    parse_res_t  res_next;

    logic        is_space;
    logic        is_hex;
    logic [3:0]  nibble;
    logic        body_char;

    // Classify the character.
    always_comb
    begin
        is_space = (text_char == 8'h20) || (text_char inside {[8'h09:8'h0D]});
        is_hex   = 1'b1;
        nibble   = 4'd0;
        if (text_char inside {["0":"9"]}) begin
            nibble = 4'(text_char - 8'h30);
        end
        else if (text_char inside {["a":"f"]}) begin
            nibble = 4'(text_char - 8'h57);
        end
        else if (text_char inside {["A":"F"]}) begin
            nibble = 4'(text_char - 8'h37);
        end
        else begin
            is_hex = 1'b0;
        end
    end

    // Advance the scan by one character.
    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        bad_next   = bad_reg;
        body_char  = 1'b0;
        case (phase_reg)
            PH_LEAD:
            begin
                if (!is_space) begin
                    phase_next = PH_BODY;
                    body_char  = (text_char != "#");
                end
            end
            PH_BODY:
            begin
                if (is_space) begin
                    phase_next = PH_TRAIL;
                end
                else begin
                    body_char = 1'b1;
                end
            end
            default:
            begin
                if (!is_space) begin
                    bad_next = 1'b1;
                end
            end
        endcase
        if (body_char) begin
            if (is_hex) begin
                acc_next = {acc_reg[27:0], nibble};
            end
            else begin
                bad_next = 1'b1;
            end
            if (count_reg < 4'd9) begin
                count_next = count_reg + 4'd1;
            end
        end
    end

    // Form the colour from the state after the last character.
    always_comb
    begin
        res_next.ok    = 1'b0;
        res_next.color = 32'd0;
        if (!bad_next) begin
            case (count_next)
                4'd3:
                begin
                    res_next.ok    = 1'b1;
                    res_next.color = {OPAQUE_ALPHA,
                                      acc_next[11:8], acc_next[11:8],
                                      acc_next[7:4], acc_next[7:4],
                                      acc_next[3:0], acc_next[3:0]};
                end
                4'd6:
                begin
                    res_next.ok    = 1'b1;
                    res_next.color = {OPAQUE_ALPHA, acc_next[23:0]};
                end
                4'd8:
                begin
                    res_next.ok    = 1'b1;
                    res_next.color = acc_next;
                end
                default:
                begin
                    res_next.ok    = 1'b0;
                    res_next.color = 32'd0;
                end
            endcase
        end
    end

    // Scan state; it clears after each last character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg   <= 32'd0;
            count_reg <= 4'd0;
            phase_reg <= PH_LEAD;
            bad_reg   <= 1'b0;
        end
        else if (take) begin
            if (last_char) begin
                acc_reg   <= 32'd0;
                count_reg <= 4'd0;
                phase_reg <= PH_LEAD;
                bad_reg   <= 1'b0;
            end
            else begin
                acc_reg   <= acc_next;
                count_reg <= count_next;
                phase_reg <= phase_next;
                bad_reg   <= bad_next;
            end
        end
    end

    // Parse outcome register.
    always_ff @(posedge clk)
    begin
        if (take && last_char) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/core/hcl_luma.sv */
module hcl_luma
    import hcl_pkg::*;
(
    input  logic [31:0] color,
    output logic        dark
);

    logic [LUMA_SUM_W-1:0] sum;

    // Three table lookups, two adds, one compare against one half.
    always_comb
    begin
        sum = LUMA_SUM_W'(LUMA_ROM_R[color[23:16]])
            + LUMA_SUM_W'(LUMA_ROM_G[color[15:8]])
            + LUMA_SUM_W'(LUMA_ROM_B[color[7:0]]);
        dark = (sum < LUMA_HALF);
    end

endmodule

/* rtl/core/hex_color_parse_and_luma_classify_core.sv */
// Hex colour parser with luminance theme classifier.
//
// text_in carries one ASCII character per transaction, with last_char set on
// the final character of a string. Whitespace around the body is skipped, an
// optional '#' may open it, and the body must hold 3, 6 or 8 hex digits.
// result_out carries one transaction per string, made on its last character:
// validity, ARGB colour, background and dark-theme flag.
// cfg writes registers: index 0 system dark preference, 1 dark background,
// 2 light background. It is always ready; write it only while idle.
//
// Path: a result moves from the parser's result register through the output
// register. Throughput: one character per cycle; the result stage and the
// output register each hold one string, and both advance under result_out
// ready, so text_in only stalls when both are full.
// Reset clears the scan state, empties both stages and restores the register
// defaults (light preference, FF000000 dark, FFFFFFFF light background).
module hex_color_parse_and_luma_classify_core
    import hcl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    hcl_char_if.sink            text_in,
    hcl_result_if.source        result_out,
    hcl_cfg_if.sink             cfg
);

    logic        sys_dark_reg;
    logic [31:0] dark_bg_reg;
    logic [31:0] light_bg_reg;

    logic        mid_valid_reg;
    logic        mid_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_ok_reg;
    logic [31:0] out_color_reg;
    logic [31:0] out_bg_reg;
    logic        out_dark_reg;

    logic        out_free;
    logic        accept;
    parse_res_t  mid_res;
    logic        luma_dark;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sys_dark_reg <= 1'b0;
            dark_bg_reg  <= DARK_BACKGROUND_RESET;
            light_bg_reg <= LIGHT_BACKGROUND_RESET;
        end
        else if (cfg.valid) begin
            case (cfg.index)
                CFG_SYSTEM_PREFERS_DARK: sys_dark_reg <= cfg.data[0];
                CFG_DARK_BACKGROUND:     dark_bg_reg  <= cfg.data;
                CFG_LIGHT_BACKGROUND:    light_bg_reg <= cfg.data;
                default:                 ;
            endcase
        end
    end

    // Handshake: the output register frees when empty or taken.
    assign out_free      = !out_valid_reg || result_out.ready;
    assign text_in.ready = !mid_valid_reg || out_free;
    assign accept        = text_in.valid && text_in.ready;

    hcl_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (accept),
        .text_char (text_in.text_char),
        .last_char (text_in.last_char),
        .res       (mid_res)
    );

    hcl_luma u_luma (
        .color (mid_res.color),
        .dark  (luma_dark)
    );

    // Stage occupancy.
    always_comb
    begin
        mid_valid_next = mid_valid_reg;
        if (accept && text_in.last_char) begin
            mid_valid_next = 1'b1;
        end
        else if (out_free) begin
            mid_valid_next = 1'b0;
        end
        out_valid_next = out_free ? mid_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register: background and theme pick the default when invalid.
    always_ff @(posedge clk)
    begin
        if (out_free && mid_valid_reg) begin
            out_ok_reg    <= mid_res.ok;
            out_color_reg <= mid_res.color;
            if (mid_res.ok) begin
                out_bg_reg   <= mid_res.color;
                out_dark_reg <= luma_dark;
            end
            else begin
                out_bg_reg   <= sys_dark_reg ? dark_bg_reg : light_bg_reg;
                out_dark_reg <= sys_dark_reg;
            end
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.parsed_ok       = out_ok_reg;
    assign result_out.color_argb      = out_color_reg;
    assign result_out.background_argb = out_bg_reg;
    assign result_out.theme_is_dark   = out_dark_reg;

endmodule

/* tb/tb_hex_color_parse_and_luma_classify_core.sv */
module tb_hex_color_parse_and_luma_classify_core
    import hcl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PERCENT  = 23;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_CHARS  = 900;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_HASH  = 8'h23;

    // Accepted body lengths and the saturation point of the digit counter.
    localparam logic [3:0] SHORT_FORM = 4'd3;
    localparam logic [3:0] RGB_FORM   = 4'd6;
    localparam logic [3:0] ARGB_FORM  = 4'd8;
    localparam logic [3:0] COUNT_CAP  = 4'd9;

    // Luminance curve: codes up to LIN_LAST_CODE sit on the linear segment.
    localparam int          LIN_LAST_CODE = 10;
    localparam logic [63:0] LIN_DIVISOR   = 64'd65892000;
    localparam logic [63:0] LIN_ROUND     = 64'd32946000;
    localparam logic [63:0] GAMMA_SCALE   = 64'd1000;
    localparam logic [63:0] GAMMA_OFFSET  = 64'd14025;
    localparam logic [63:0] GAMMA_DENOM   = 64'd269025;
    localparam logic [63:0] POW_DIVISOR   = 64'd2560000;
    localparam logic [63:0] POW_ROUND     = 64'd1280000;
    localparam int          Q_BITS        = 60;
    localparam logic [63:0] CHANNEL_WEIGHT [3] = '{64'd2126, 64'd7152, 64'd722};

    typedef struct {
        logic        ok;
        logic [31:0] color;
        logic [31:0] bg;
        logic        dark;
    } color_report_t;

    typedef logic [7:0] text_t[$];

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hcl_char_if   char_bus();
    hcl_result_if report_bus();
    hcl_cfg_if    cfg_bus();

    hex_color_parse_and_luma_classify_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (char_bus),
        .result_out (report_bus),
        .cfg        (cfg_bus)
    );

    // Parser state and register copies kept by the testbench.
    logic [31:0]     digit_acc;
    logic [3:0]      digit_total;
    scan_phase_t     phase;
    logic            broken;
    logic            prefer_dark;
    logic [31:0]     dark_bg;
    logic [31:0]     light_bg;
    logic [LUMA_ROM_W-1:0] luma_lut [3][256];

    color_report_t reports_due[$];
    int  mismatch_total = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  steady = 1'b0;

    always #CLK_HALF clk = ~clk;

    // Fixed-point helpers for the luminance tables, values in Q4.60.
    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = 128'(a) * 128'(b);
        return 64'(prod >> Q_BITS);
    endfunction

    function automatic logic [63:0] fx_pow5(input logic [63:0] t);
        logic [63:0] sq;
        logic [63:0] quad;
        sq   = fx_mul(t, t);
        quad = fx_mul(sq, sq);
        return fx_mul(quad, t);
    endfunction

    // Largest value whose fifth power stays at or below x, found bit by bit.
    function automatic logic [63:0] fx_root5(input logic [63:0] x);
        logic [63:0] t;
        logic [63:0] trial;
        t = 64'd0;
        for (int b = Q_BITS; b >= 0; b--) begin
            trial = t | (64'd1 << b);
            if (fx_pow5(trial) <= x) begin
                t = trial;
            end
        end
        return t;
    endfunction

    // Weighted linearized channel value in unsigned Q0.n, rounded half up.
    function automatic logic [LUMA_ROM_W-1:0] luma_weighted(input logic [63:0] w,
                                                            input int v);
        logic [63:0]  code;
        logic [127:0] quot;
        logic [63:0]  x2;
        logic [63:0]  lin;
        logic [127:0] prod;
        logic [63:0]  scaled;
        code = 64'(v);
        if (v <= LIN_LAST_CODE) begin
            return LUMA_ROM_W'((((64'd2 * w * code) << LUMA_FRACTION_BITS) + LIN_ROUND)
                               / LIN_DIVISOR);
        end
        else begin
            quot   = (128'(GAMMA_SCALE * code + GAMMA_OFFSET) << Q_BITS) / 128'(GAMMA_DENOM);
            x2     = fx_mul(quot[63:0], quot[63:0]);
            lin    = fx_mul(x2, fx_root5(x2));
            prod   = 128'(lin) * 128'(w);
            scaled = prod[52 - LUMA_FRACTION_BITS +: 64];
            return LUMA_ROM_W'((scaled + POW_ROUND) / POW_DIVISOR);
        end
    endfunction

    function automatic logic [LUMA_SUM_W-1:0] luma_of(input logic [31:0] argb);
        return LUMA_SUM_W'(luma_lut[0][argb[23:16]]) + LUMA_SUM_W'(luma_lut[1][argb[15:8]])
             + LUMA_SUM_W'(luma_lut[2][argb[7:0]]);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void clear_scan();
        digit_acc   = 32'd0;
        digit_total = 4'd0;
        phase       = PH_LEAD;
        broken      = 1'b0;
    endfunction

    // Advances the parser by one accepted character; the last one queues a report.
    function automatic void step_parser(input logic [7:0] c, input logic last);
        logic          blank;
        logic          in_body;
        logic          is_hex;
        logic [3:0]    nib;
        color_report_t rep;
        blank   = is_blank(c);
        in_body = 1'b0;
        is_hex  = 1'b1;
        nib     = 4'd0;
        if (phase == PH_LEAD) begin
            if (!blank) begin
                phase   = PH_BODY;
                in_body = (c != CH_HASH);
            end
        end
        else if (phase == PH_BODY) begin
            in_body = 1'b1;
        end
        else if (!blank) begin
            broken = 1'b1;
        end

        if (in_body) begin
            if (blank) begin
                phase = PH_TRAIL;
            end
            else begin
                if (c >= "0" && c <= "9") begin
                    nib = 4'(c - "0");
                end
                else if (c >= "a" && c <= "f") begin
                    nib = 4'(c - "a" + 8'd10);
                end
                else if (c >= "A" && c <= "F") begin
                    nib = 4'(c - "A" + 8'd10);
                end
                else begin
                    is_hex = 1'b0;
                end
                if (is_hex) begin
                    digit_acc = {digit_acc[27:0], nib};
                end
                else begin
                    broken = 1'b1;
                end
                if (digit_total < COUNT_CAP) begin
                    digit_total++;
                end
            end
        end

        if (last) begin
            rep.ok    = 1'b0;
            rep.color = 32'd0;
            if (!broken) begin
                if (digit_total == SHORT_FORM) begin
                    rep.ok    = 1'b1;
                    rep.color = {OPAQUE_ALPHA, {2{digit_acc[11:8]}}, {2{digit_acc[7:4]}},
                                 {2{digit_acc[3:0]}}};
                end
                else if (digit_total == RGB_FORM) begin
                    rep.ok    = 1'b1;
                    rep.color = {OPAQUE_ALPHA, digit_acc[23:0]};
                end
                else if (digit_total == ARGB_FORM) begin
                    rep.ok    = 1'b1;
                    rep.color = digit_acc;
                end
            end
            if (rep.ok) begin
                rep.bg   = rep.color;
                rep.dark = luma_of(rep.color) < LUMA_HALF;
            end
            else begin
                rep.bg   = prefer_dark ? dark_bg : light_bg;
                rep.dark = prefer_dark;
            end
            reports_due.push_back(rep);
            clear_scan();
        end
    endfunction

    function automatic text_t as_text(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++) begin
            t.push_back(s[i]);
        end
        return t;
    endfunction

    function automatic logic [7:0] random_blank();
        int r;
        r = $urandom_range(5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] random_hex();
        int r;
        r = $urandom_range(15);
        if (r < 10) begin
            return "0" + 8'(r);
        end
        else begin
            return ($urandom_range(1) ? "a" : "A") + 8'(r - 10);
        end
    endfunction

    // Mostly well-formed colors with random content; some broken, some pure noise.
    function automatic text_t random_string();
        text_t t;
        int    kind;
        int    n;
        int    pos;
        kind = $urandom_range(99);
        if (kind < 10) begin
            n = $urandom_range(6, 1);
            repeat (n) t.push_back(8'($urandom_range(255)));
        end
        else begin
            repeat ($urandom_range(2)) t.push_back(random_blank());
            if ($urandom_range(1)) begin
                t.push_back(CH_HASH);
            end
            if ($urandom_range(99) < 85) begin
                case ($urandom_range(2))
                    0:       n = int'(SHORT_FORM);
                    1:       n = int'(RGB_FORM);
                    default: n = int'(ARGB_FORM);
                endcase
            end
            else begin
                n = $urandom_range(10);
            end
            repeat (n) t.push_back(random_hex());
            repeat ($urandom_range(2)) t.push_back(random_blank());
            if (kind >= 85 && t.size() > 0) begin
                pos = $urandom_range(t.size() - 1);
                case ($urandom_range(2))
                    0:       t[pos] = 8'($urandom_range(255));
                    1:       t.insert(pos, CH_HASH);
                    default: t.insert(pos, random_blank());
                endcase
            end
        end
        if (t.size() == 0) begin
            t.push_back(8'($urandom_range(255)));
        end
        return t;
    endfunction

    // Offers one character and waits for its transaction.
    task automatic send_char(input logic [7:0] c, input logic last);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                @(negedge clk);
                char_bus.valid <= 1'b0;
            end
        end
        @(negedge clk);
        char_bus.valid     <= 1'b1;
        char_bus.text_char <= c;
        char_bus.last_char <= last;
        do @(posedge clk); while (char_bus.ready !== 1'b1);
        step_parser(c, last);
    endtask

    task automatic send_text(input text_t s);
        foreach (s[i]) begin
            send_char(s[i], i == s.size() - 1);
        end
    endtask

    // Stops offering characters and waits until every report has come back.
    task automatic quiesce();
        @(negedge clk);
        char_bus.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        case (idx)
            CFG_SYSTEM_PREFERS_DARK: prefer_dark = data[0];
            CFG_DARK_BACKGROUND:     dark_bg     = data;
            CFG_LIGHT_BACKGROUND:    light_bg    = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Invalid strings under the reset register values.
    task automatic test_reset_defaults();
        send_text(as_text("#"));
        send_text(as_text(" \t\n\v\f\r"));
        send_text(as_text("xyz"));
    endtask

    // Three, six and eight digit bodies, with and without '#' and padding, and bodies of other lengths.
    task automatic test_digit_forms();
        send_text(as_text("#fA0"));
        send_text(as_text(" 1234ab\n"));
        send_text(as_text("#80FF00ff"));
        send_text(as_text("00ffffff"));
        send_text(as_text("12345"));
        send_text(as_text("123456789A"));
        send_text(as_text("a"));
    endtask

    // Late hash, split body, non-hex bytes and near-whitespace control bytes.
    task automatic test_malformed_forms();
        text_t t;
        send_text(as_text("##abc"));
        send_text(as_text("#ab c"));
        send_text(as_text("ab#c"));
        send_text(as_text("abc  x"));
        t = '{8'h00};
        send_text(t);
        t = '{"a", 8'h80, "b"};
        send_text(t);
        t = '{8'h08, "a", "b", "c"};
        send_text(t);
        t = '{"a", "b", "c", 8'h0E};
        send_text(t);
    endtask

    // Every register at its extremes, seen through invalid strings and one valid one.
    task automatic test_config_registers();
        quiesce();
        write_reg(CFG_SYSTEM_PREFERS_DARK, 32'd1);
        write_reg(CFG_DARK_BACKGROUND, 32'h0000_0000);
        write_reg(CFG_LIGHT_BACKGROUND, 32'h0000_0000);
        send_text(as_text("q"));
        send_text(as_text("#abc"));
        quiesce();
        write_reg(CFG_DARK_BACKGROUND, 32'hFFFF_FFFF);
        send_text(as_text("z"));
        quiesce();
        write_reg(CFG_SYSTEM_PREFERS_DARK, 32'd0);
        write_reg(CFG_LIGHT_BACKGROUND, $urandom());
        send_text(as_text(" "));
    endtask

    // Grays straddling the dark threshold, segment boundary and primaries.
    task automatic test_luma_threshold();
        int g;
        g = 1;
        while (g < 255 && luma_of({8'h00, {3{8'(g)}}}) < LUMA_HALF) begin
            g++;
        end
        send_text(as_text($sformatf("#%02x%02x%02x", g - 1, g - 1, g - 1)));
        send_text(as_text($sformatf("#%02x%02x%02x", g, g, g)));
        send_text(as_text("#0a0b0a"));
        send_text(as_text("#ff0000"));
        send_text(as_text("#00ff00"));
        send_text(as_text("#0000FF"));
    endtask

    // The report side stalls for a long stretch while characters keep coming.
    task automatic test_report_backpressure();
        quiesce();
        hold_left = HOLD_CYCLES;
        repeat (12) begin
            send_text(as_text($sformatf("%03x", $urandom_range(4095))));
        end
    endtask

    // Random strings in three rounds with fresh register values; the middle
    // round runs without any idle cycles.
    task automatic test_random_strings();
        text_t s;
        int    sent;
        for (int round = 0; round < 3; round++) begin
            quiesce();
            write_reg(CFG_SYSTEM_PREFERS_DARK, $urandom_range(1));
            write_reg(CFG_DARK_BACKGROUND, $urandom());
            write_reg(CFG_LIGHT_BACKGROUND, $urandom());
            steady = (round == 1);
            sent = 0;
            while (sent < RANDOM_CHARS / 3) begin
                s = random_string();
                send_text(s);
                sent += s.size();
            end
        end
        steady = 1'b0;
    endtask

    // Report side readiness, with random stalls and the long hold-off.
    always @(negedge clk) begin
        report_bus.ready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
        end
    end

    // Each report transaction is checked against the oldest pending string.
    always @(posedge clk) begin : check_report
        color_report_t want;
        if (rst_n && report_bus.valid === 1'b1 && report_bus.ready === 1'b1) begin
            if (reports_due.size() == 0) begin
                $error("report with no string pending: color_argb %08h", report_bus.color_argb);
                mismatch_total++;
            end
            else begin
                want = reports_due.pop_front();
                if (report_bus.parsed_ok !== want.ok) begin
                    $error("parsed_ok: expected %0b, got %0b", want.ok, report_bus.parsed_ok);
                    mismatch_total++;
                end
                if (report_bus.color_argb !== want.color) begin
                    $error("color_argb: expected %08h, got %08h", want.color,
                           report_bus.color_argb);
                    mismatch_total++;
                end
                if (report_bus.background_argb !== want.bg) begin
                    $error("background_argb: expected %08h, got %08h", want.bg,
                           report_bus.background_argb);
                    mismatch_total++;
                end
                if (report_bus.theme_is_dark !== want.dark) begin
                    $error("theme_is_dark: expected %0b, got %0b", want.dark,
                           report_bus.theme_is_dark);
                    mismatch_total++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_hex_color_parse_and_luma_classify_core: errors");
            $finish;
        end
    end

    initial begin
        char_bus.valid     = 1'b0;
        char_bus.text_char = 8'd0;
        char_bus.last_char = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = CFG_SYSTEM_PREFERS_DARK;
        cfg_bus.data       = 32'd0;
        report_bus.ready   = 1'b0;

        for (int ch = 0; ch < 3; ch++) begin
            for (int v = 0; v < 256; v++) begin
                luma_lut[ch][v] = luma_weighted(CHANNEL_WEIGHT[ch], v);
            end
        end
        prefer_dark = 1'b0;
        dark_bg     = DARK_BACKGROUND_RESET;
        light_bg    = LIGHT_BACKGROUND_RESET;
        clear_scan();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_digit_forms();
        test_malformed_forms();
        test_luma_threshold();
        test_config_registers();
        test_report_backpressure();
        test_random_strings();
        quiesce();

        if (mismatch_total == 0) begin
            $display("tb_hex_color_parse_and_luma_classify_core: clean");
        end
        else begin
            $display("tb_hex_color_parse_and_luma_classify_core: errors");
        end
        $finish;
    end

endmodule
